// ----- rtl/core/ptsft_pkg.sv -----
// ptsft_pkg: shared widths, constants and types of the pts to frame timestamp tracker
// used by ptsft_div, the top level and the port checker; depends on nothing

package ptsft_pkg;

    localparam int PTS_W      = 33;
    localparam int TIME_W     = 35;
    localparam int TREF_W     = 10;
    localparam int FPS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIVIDEND_W = 44;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int PROD1_W    = 27;
    localparam int PROD2_W    = 43;
    localparam int OFS_W      = 26;
    localparam int DIFF_W     = 36;
    localparam int SYNC_W     = 46;

    localparam logic [CFG_IDX_W-1:0] CFG_FPS_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS_DEN = 2'd1;

    localparam logic [FPS_W-1:0] FPS_NUM_RST = 16'd25;
    localparam logic [FPS_W-1:0] FPS_DEN_RST = 16'd1;

    localparam logic [16:0]          TICKS_PER_S  = 17'd90000;
    localparam logic [DIVISOR_W-1:0] TICKS_PER_MS = 16'd90;
    localparam logic [9:0]           MS_PER_S     = 10'd1000;

    localparam logic signed [DIFF_W-1:0] BACK_LIMIT = -36'sd18000;
    localparam logic signed [DIFF_W-1:0] FWD_LIMIT  = 36'sd450000;

    localparam logic signed [TIME_W-1:0] TIME_MIN    = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [PTS_W-1:0]         MIN_PTS_RST = '1;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SEEN,
        MODE_SYNC
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_PROD,
        S_DIVA,
        S_DIVB,
        S_FIX,
        S_DIVC,
        S_PEAK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/ptsft_div.sv -----
// ptsft_div: restoring serial divider, one quotient bit per cycle
// depends on ptsft_pkg for widths and the request/response structs

module ptsft_div import ptsft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fit;
    logic [DIVISOR_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_fit   = (w_trial >= {1'b0, r_divisor});
        w_diff  = w_trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload: dividend shifts out of the top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/core/pts_to_frame_timestamp_tracker_core.sv -----
// pts_to_frame_timestamp_tracker_core: top level, sequencer and tracker state
// depends on ptsft_pkg and ptsft_div
//
// Usage:
// One input beat per video picture: has_pts, pts (33-bit, 90 kHz), temporal_ref
// and is_i_frame on a valid/ready channel. Each picture yields exactly one
// output beat with the frame timestamp, the peak timestamp, the jump flag and
// the first pts-to-time anchor, on a second valid/ready channel.
// The frame rate is set through the write port: index 0 numerator, index 1
// denominator; other indexes are dropped. Write only while no picture is in work.
// The work per picture depends on its path: no division when no pts has been seen
// or a jump holds the timestamp, one in the common case, three when a new minimum
// pts restarts the timeline. The one serial divider serves up to three divisions
// per picture (tick period, millisecond offset, ticks to ms).
// One picture is in work at a time; ready is high only when the sequencer is idle,
// so a new input beat is taken only once the last result is in the output register.
// The output register holds a finished beat while the receiver stalls, and the
// next picture is already taken in meanwhile; its result waits until that beat goes.
// Synchronous reset restores 25/1 fps, zeroes tracker state but min pts (all ones).

module pts_to_frame_timestamp_tracker_core import ptsft_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [FPS_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_has_pts,
    input  logic [PTS_W-1:0]            i_pts,
    input  logic [TREF_W-1:0]           i_temporal_ref,
    input  logic                        i_is_i_frame,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [TIME_W-1:0]    o_frame_time_ms,
    output logic signed [TIME_W-1:0]    o_max_time_ms,
    output logic                        o_jump_seen,
    output logic                        o_anchor_valid,
    output logic [PTS_W-1:0]            o_anchor_pts,
    output logic signed [TIME_W-1:0]    o_anchor_time_ms
);

    t_state r_state, n_state;

    logic [FPS_W-1:0]          r_fps_num;
    logic [FPS_W-1:0]          r_fps_den;

    t_mode                     r_mode;
    logic [PTS_W-1:0]          r_last_pts;
    logic [PTS_W-1:0]          r_min_pts;
    logic signed [TIME_W-1:0]  r_sync_ref;
    logic [OFS_W-1:0]          r_offset;
    logic signed [TIME_W-1:0]  r_now;
    logic signed [TIME_W-1:0]  r_peak;
    logic                      r_anchor;
    logic [PTS_W-1:0]          r_anchor_pts;
    logic signed [TIME_W-1:0]  r_anchor_ms;

    logic [TREF_W-1:0]         r_tref;
    logic                      r_is_i;
    logic                      r_jump;
    logic                      r_span_neg;
    logic [PROD1_W-1:0]        r_prod1;
    logic [PROD2_W-1:0]        r_prod2;

    logic                      r_out_valid;

    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    logic [FPS_W-1:0]          w_num_eff;
    logic signed [DIFF_W-1:0]  w_jump_d;
    logic                      w_jump;
    logic                      w_hold;
    logic                      w_upd;
    logic signed [SYNC_W-1:0]  w_sync_new;
    logic signed [TIME_W-1:0]  w_sync_sat;
    logic signed [PTS_W:0]     w_span;
    logic [PTS_W:0]            w_span_abs;
    logic [TIME_W-1:0]         w_q35;
    logic signed [TIME_W-1:0]  w_now;
    logic                      w_tref_zero;
    logic                      w_out_load;

    ptsft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // datapath terms
    always_comb begin
        w_num_eff   = (r_fps_num == '0) ? FPS_W'(1) : r_fps_num;
        w_tref_zero = (r_tref == '0);
        w_jump_d    = $signed({3'b000, r_last_pts})
                    - $signed({r_sync_ref[TIME_W-1], r_sync_ref});
        w_jump      = (r_mode == MODE_SYNC)
                    && ((w_jump_d < BACK_LIMIT) || (w_jump_d >= FWD_LIMIT));
        w_hold      = w_jump && !w_tref_zero && !r_is_i;
        w_upd       = (r_last_pts < r_min_pts) && !w_jump;
        w_sync_new  = $signed({13'b0, r_last_pts}) - $signed({2'b00, w_div_rsp.quotient});
        // only the low side can overflow: the subtracted period is never negative
        w_sync_sat  = (w_sync_new < $signed({{(SYNC_W-TIME_W){1'b1}}, TIME_MIN}))
                    ? TIME_MIN : w_sync_new[TIME_W-1:0];
        w_span      = $signed({1'b0, r_last_pts}) - $signed({1'b0, r_min_pts});
        w_span_abs  = w_span[PTS_W] ? (~w_span + 1'b1) : w_span;
        w_q35       = w_div_rsp.quotient[TIME_W-1:0];
        // ticks to ms truncates toward zero, so divide the magnitude
        w_now       = $signed(r_span_neg ? (~w_q35 + 1'b1) : w_q35)
                    + $signed({{(TIME_W-OFS_W){1'b0}}, r_offset});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EVAL;
            S_EVAL: begin
                if (r_mode == MODE_NONE || w_hold) n_state = S_EMIT;
                else if (w_upd)                   n_state = S_MUL;
                else                              n_state = S_FIX;
            end
            S_MUL:  n_state = S_PROD;
            S_PROD: n_state = S_DIVA;
            S_DIVA: if (w_div_rsp.done) n_state = S_DIVB;
            S_DIVB: if (w_div_rsp.done) n_state = S_FIX;
            S_FIX:  n_state = S_DIVC;
            S_DIVC: if (w_div_rsp.done) n_state = S_PEAK;
            S_PEAK: n_state = S_EMIT;
            S_EMIT: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready         = 1'b0;
        w_out_load         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DIVIDEND_W'(r_prod2);
        w_div_req.divisor  = w_num_eff;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_PROD: w_div_req.start = 1'b1;
            S_DIVA: begin
                w_div_req.start    = w_div_rsp.done;
                w_div_req.dividend = DIVIDEND_W'(OFS_W'(r_fps_den) * OFS_W'(MS_PER_S));
            end
            S_FIX: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIVIDEND_W'(w_span_abs[PTS_W-1:0]);
                w_div_req.divisor  = TICKS_PER_MS;
            end
            S_EMIT: w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps_num <= FPS_NUM_RST;
            r_fps_den <= FPS_DEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FPS_NUM: r_fps_num <= i_cfg_data;
                CFG_FPS_DEN: r_fps_den <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NONE;
            r_last_pts   <= '0;
            r_min_pts    <= MIN_PTS_RST;
            r_sync_ref   <= '0;
            r_offset     <= '0;
            r_now        <= '0;
            r_peak       <= '0;
            r_anchor     <= 1'b0;
            r_anchor_pts <= '0;
            r_anchor_ms  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_has_pts) begin
                        r_last_pts <= i_pts;
                        if (r_mode == MODE_NONE) r_mode <= MODE_SEEN;
                    end
                end
                S_EVAL: begin
                    if (r_mode != MODE_NONE) begin
                        if (w_hold) r_now  <= r_peak;
                        else        r_mode <= MODE_SYNC;
                    end
                end
                S_DIVA: begin
                    if (w_div_rsp.done) begin
                        r_sync_ref <= w_sync_sat;
                        r_min_pts  <= r_last_pts;
                    end
                end
                S_DIVB: begin
                    if (w_div_rsp.done) begin
                        r_offset <= w_tref_zero ? '0 : w_div_rsp.quotient[OFS_W-1:0];
                    end
                end
                S_FIX: begin
                    if (w_tref_zero) r_sync_ref <= $signed({2'b00, r_last_pts});
                end
                S_DIVC: begin
                    if (w_div_rsp.done) r_now <= w_now;
                end
                S_PEAK: begin
                    if (!r_anchor) begin
                        r_anchor     <= 1'b1;
                        r_anchor_pts <= r_last_pts;
                        r_anchor_ms  <= r_now;
                    end
                    if (r_now > r_peak) r_peak <= r_now;
                end
                default: ;
            endcase
        end
    end

    // per-picture working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_tref <= i_temporal_ref;
            r_is_i <= i_is_i_frame;
        end
        // tick period product is ready before the divider starts on it
        if (r_state == S_EVAL) begin
            r_jump  <= w_jump;
            r_prod1 <= PROD1_W'(r_tref) * PROD1_W'(TICKS_PER_S);
        end
        if (r_state == S_MUL) begin
            r_prod2 <= PROD2_W'(r_prod1) * PROD2_W'(r_fps_den);
        end
        if (r_state == S_FIX) begin
            r_span_neg <= w_span[PTS_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_frame_time_ms  <= r_now;
            o_max_time_ms    <= r_peak;
            o_jump_seen      <= r_jump;
            o_anchor_valid   <= r_anchor;
            o_anchor_pts     <= r_anchor_pts;
            o_anchor_time_ms <= r_anchor_ms;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/ptsft_chk.sv -----
// ptsft_chk: port-level checker for the pts to frame timestamp tracker, with its bind
// depends on ptsft_pkg and pts_to_frame_timestamp_tracker_core

module ptsft_chk import ptsft_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [TIME_W-1:0] o_frame_time_ms,
    input logic signed [TIME_W-1:0] o_max_time_ms,
    input logic                     o_jump_seen,
    input logic                     o_anchor_valid
);

    // one picture in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an input beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_frame_time_ms)))
        else $error("stalled output beat changed");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_time_ms >= o_frame_time_ms))
        else $error("frame time above peak time");

    // before the anchor nothing is tracked yet
    a_pre_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_anchor_valid) |->
            (o_frame_time_ms == '0 && o_max_time_ms == '0 && !o_jump_seen))
        else $error("timestamp moved before anchor");

    a_anchor_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_anchor_valid) |=> o_anchor_valid)
        else $error("anchor valid dropped");

endmodule

bind pts_to_frame_timestamp_tracker_core ptsft_chk u_ptsft_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_frame_time_ms (o_frame_time_ms),
    .o_max_time_ms   (o_max_time_ms),
    .o_jump_seen     (o_jump_seen),
    .o_anchor_valid  (o_anchor_valid)
);
